@@ rtl/asm_pkg.sv @@
// Shared types and constants for the auto-stop threshold monitor.
// Used by asm_csr, asm_eval and the top level; depends on nothing.
`default_nettype none

package asm_pkg;

   // Default number of consecutive low samples before a stop
   localparam int unsigned STOP_SAMPLES_DEF = 10;

   // Register port geometry: five 32-bit registers at 4-byte spacing
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MON_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURR_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MINUTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_MODE   = 3'd4;

   // Stop reason codes
   localparam logic [1:0] REASON_NONE     = 2'd0;
   localparam logic [1:0] REASON_MAX_TIME = 2'd1;
   localparam logic [1:0] REASON_LOW_HELD = 2'd2;

   // Time limit: minutes to seconds; arming: value > 6/5 of threshold
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned LIMIT_S_W          = 22;
   localparam int unsigned ARM_MUL_VALUE      = 5;
   localparam int unsigned ARM_MUL_LIMIT      = 6;

   typedef struct packed {
      logic        monitor_enable;
      logic [15:0] voltage_limit_mv;
      logic [22:0] current_limit;
      logic [15:0] max_minutes;
      logic        falling_edge_mode;
   } cfg_type;

   typedef struct packed {
      logic               recording;
      logic [15:0]        bus_mv;
      logic signed [23:0] current_tenth_ma;
      logic [22:0]        rec_time_s;
   } sample_type;

   typedef struct packed {
      logic       stop_now;
      logic [1:0] stop_reason;
      logic [7:0] low_count;
      logic       voltage_armed;
      logic       current_armed;
   } result_type;

   typedef struct packed {
      logic [7:0] low_counter;
      logic       armed_volt;
      logic       armed_curr;
   } mon_state_type;

endpackage

`default_nettype wire

@@ rtl/auto_stop_threshold_monitor_unit.sv @@
// Auto-stop threshold monitor for one measurement channel. Takes one sample
// item per clock unless the result channel stalls, and returns one result
// item per sample: a stop request when the recording time limit is reached
// or when a low voltage/current condition has held for STOP_SAMPLES
// consecutive samples. Samples are captured in an input register, evaluated
// by one layer of compare logic that also updates the low counter and arm
// flags, and land in a result register once it has room; the sustained rate
// is one sample per cycle while rsp_ready holds, set by that single
// evaluation stage and its state registers. Registers are to be written over
// the csr_ port only while no sample is in flight; the block does not
// enforce this. Depends on asm_pkg, asm_csr and asm_eval.
`default_nettype none

module auto_stop_threshold_monitor_unit
   import asm_pkg::*;
#(
   parameter int unsigned STOP_SAMPLES = STOP_SAMPLES_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_recording,
   input  wire logic [15:0]           req_bus_mv,
   input  wire logic signed [23:0]    req_current_tenth_ma,
   input  wire logic [22:0]           req_rec_time_s,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_stop_now,
   output logic [1:0]                 rsp_stop_reason,
   output logic [7:0]                 rsp_low_count,
   output logic                       rsp_voltage_armed,
   output logic                       rsp_current_armed,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg;
   sample_type    smp_ff;
   logic          smp_vld_ff;
   logic          smp_vld_in;
   result_type    res_ff;
   logic          res_vld_ff;
   logic          res_vld_in;
   mon_state_type state_ff;
   mon_state_type state_in;
   mon_state_type state_eval;
   result_type    res_eval;
   logic          advance;

   assign csr_pready = 1'b1;

   asm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   asm_eval #(
      .STOP_SAMPLES (STOP_SAMPLES)
   ) u_eval (
      .cfg       (cfg),
      .sample    (smp_ff),
      .state_cur (state_ff),
      .state_nxt (state_eval),
      .result    (res_eval)
   );

   // Item moves from input register to result register when there is room
   assign advance    = smp_vld_ff && (!res_vld_ff || rsp_ready);
   assign req_ready  = !smp_vld_ff || advance;
   assign smp_vld_in = (req_valid && req_ready) || (smp_vld_ff && !advance);
   assign res_vld_in = advance || (res_vld_ff && !rsp_ready);
   assign state_in   = advance ? state_eval : state_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         smp_vld_ff <= smp_vld_in;
         res_vld_ff <= res_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_ff.recording        <= req_recording;
         smp_ff.bus_mv           <= req_bus_mv;
         smp_ff.current_tenth_ma <= req_current_tenth_ma;
         smp_ff.rec_time_s       <= req_rec_time_s;
      end
      if (advance) begin
         res_ff <= res_eval;
      end
   end

   assign rsp_valid         = res_vld_ff;
   assign rsp_stop_now      = res_ff.stop_now;
   assign rsp_stop_reason   = res_ff.stop_reason;
   assign rsp_low_count     = res_ff.low_count;
   assign rsp_voltage_armed = res_ff.voltage_armed;
   assign rsp_current_armed = res_ff.current_armed;

   // A low-held stop only once the counter has reached the limit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_reason == REASON_LOW_HELD) |->
         (rsp_low_count >= 8'(STOP_SAMPLES)))
      else $error("low-held stop below sample limit");

   // Stop flag and reason agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stop_now == (rsp_stop_reason != REASON_NONE)))
      else $error("stop flag and reason disagree");

   // Arm flags are only cleared by reset
   assert property (@(posedge clock)
      (!reset && !$past(reset)) |->
         (!$fell(state_ff.armed_volt) && !$fell(state_ff.armed_curr)))
      else $error("arm flag cleared outside reset");

endmodule

`default_nettype wire

@@ rtl/asm_csr.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on asm_pkg for the register indexes and cfg_type.
`default_nettype none

module asm_csr
   import asm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output cfg_type                    cfg
);

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [CSR_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   // Write decode; indexes past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_MON_ENABLE:  cfg_in.monitor_enable    = csr_pwdata[0];
            CSR_VOLT_LIMIT:  cfg_in.voltage_limit_mv  = csr_pwdata[15:0];
            CSR_CURR_LIMIT:  cfg_in.current_limit     = csr_pwdata[22:0];
            CSR_MAX_MINUTES: cfg_in.max_minutes       = csr_pwdata[15:0];
            CSR_FALL_MODE:   cfg_in.falling_edge_mode = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         CSR_MON_ENABLE:  csr_prdata = {31'd0, cfg_ff.monitor_enable};
         CSR_VOLT_LIMIT:  csr_prdata = {16'd0, cfg_ff.voltage_limit_mv};
         CSR_CURR_LIMIT:  csr_prdata = {9'd0, cfg_ff.current_limit};
         CSR_MAX_MINUTES: csr_prdata = {16'd0, cfg_ff.max_minutes};
         CSR_FALL_MODE:   csr_prdata = {31'd0, cfg_ff.falling_edge_mode};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/asm_eval.sv @@
// Per-sample stop decision: duration limit, threshold tests, arming and
// the saturating low counter. Pure logic; depends on asm_pkg.
`default_nettype none

module asm_eval
   import asm_pkg::*;
#(
   parameter int unsigned STOP_SAMPLES = STOP_SAMPLES_DEF
)(
   input  wire cfg_type       cfg,
   input  wire sample_type    sample,
   input  wire mon_state_type state_cur,
   output mon_state_type      state_nxt,
   output result_type         result
);

   localparam logic [7:0] STOP_LIM = 8'(STOP_SAMPLES);

   logic [LIMIT_S_W-1:0] limit_s;
   logic                 time_up;
   logic [18:0]          v_x5;
   logic [18:0]          vt_x6;
   logic signed [27:0]   c_ext;
   logic signed [27:0]   ct_ext;
   logic signed [27:0]   c_x5;
   logic signed [27:0]   ct_x6;
   logic                 v_on;
   logic                 c_on;
   logic                 arm_v;
   logic                 arm_c;
   logic                 v_low;
   logic                 c_low;
   logic                 low;
   logic [7:0]           cnt_nxt;

   // Duration limit in seconds
   assign limit_s = LIMIT_S_W'(cfg.max_minutes) * LIMIT_S_W'(SECONDS_PER_MINUTE);
   assign time_up = (cfg.max_minutes != '0) && (sample.rec_time_s >= {1'b0, limit_s});

   // Arming compares: 5 x value > 6 x threshold, exact
   assign v_x5   = 19'(sample.bus_mv) * 19'(ARM_MUL_VALUE);
   assign vt_x6  = 19'(cfg.voltage_limit_mv) * 19'(ARM_MUL_LIMIT);
   assign c_ext  = 28'(sample.current_tenth_ma);
   assign ct_ext = $signed({5'd0, cfg.current_limit});
   assign c_x5   = c_ext * 28'sd5;
   assign ct_x6  = ct_ext * 28'sd6;

   assign v_on = (cfg.voltage_limit_mv != '0);
   assign c_on = (cfg.current_limit != '0);

   assign arm_v = state_cur.armed_volt ||
                  (v_on && cfg.falling_edge_mode && (v_x5 > vt_x6));
   assign arm_c = state_cur.armed_curr ||
                  (c_on && cfg.falling_edge_mode && (c_x5 > ct_x6));

   // Low tests; in falling-edge mode only once armed
   assign v_low = v_on && (sample.bus_mv < cfg.voltage_limit_mv) &&
                  (!cfg.falling_edge_mode || arm_v);
   assign c_low = c_on && (c_ext < ct_ext) &&
                  (!cfg.falling_edge_mode || arm_c);
   assign low   = v_low || c_low;

   // Saturating counter of consecutive low samples
   assign cnt_nxt = !low ? 8'd0 :
                    (state_cur.low_counter == 8'hFF) ? 8'hFF :
                    state_cur.low_counter + 8'd1;

   always_comb begin
      state_nxt            = state_cur;
      result.stop_now      = 1'b0;
      result.stop_reason   = REASON_NONE;
      result.low_count     = state_cur.low_counter;
      result.voltage_armed = state_cur.armed_volt;
      result.current_armed = state_cur.armed_curr;
      if (sample.recording && cfg.monitor_enable) begin
         if (time_up) begin
            result.stop_now    = 1'b1;
            result.stop_reason = REASON_MAX_TIME;
         end else begin
            state_nxt.low_counter = cnt_nxt;
            state_nxt.armed_volt  = arm_v;
            state_nxt.armed_curr  = arm_c;
            result.low_count      = cnt_nxt;
            result.voltage_armed  = arm_v;
            result.current_armed  = arm_c;
            if (low && (cnt_nxt >= STOP_LIM)) begin
               result.stop_now    = 1'b1;
               result.stop_reason = REASON_LOW_HELD;
            end
         end
      end
   end

endmodule

`default_nettype wire
